FILE: rtl/core/fbp_pkg.sv
// Shared types, widths and constants for the FFT bin polar converter.
// Used by fbp_mag_pipe, fbp_cordic_pipe, the top level and the port checker.
// No dependencies.
`default_nettype none

package fbp_pkg;

  localparam int DATA_W   = 32;
  localparam int COORD_W  = 10;
  localparam int MAG_W    = 24;
  localparam int PHASE_W  = 16;
  localparam int CFG_W    = 4;

  localparam int MAX_SIDE_LOG2_DEF = 10;
  localparam int CORDIC_STAGES_DEF = 24;

  // square root: one result bit per stage over a 64-bit radicand
  localparam int SQRT_STEPS = 32;
  localparam int SQ_W       = 2 * SQRT_STEPS;

  // rotator slots; slots past the configured stage count only delay
  localparam int CORDIC_MAX = 32;
  localparam int CORDIC_W   = 35;

  // register stages behind the capture stage, same on both paths
  localparam int PIPE_DEPTH = SQRT_STEPS + 3;

  localparam logic [CFG_W-1:0]   SIDE_LOG2_RST = 4'd9;
  localparam logic [MAG_W-1:0]   MAG_MAX       = 24'hFF_FFFF;
  localparam logic [PHASE_W-1:0] PHASE_SCALE   = 16'd65280;

  typedef logic signed [DATA_W-1:0]   sample_t;
  typedef logic signed [CORDIC_W-1:0] cval_t;

  typedef struct packed {
    logic             adv;
    logic [CFG_W-1:0] side_log2;
  } pipe_ctl_t;

  typedef struct packed {
    logic [MAG_W-1:0]   magnitude;
    logic [PHASE_W-1:0] phase_level;
    logic [COORD_W-1:0] dest_row;
    logic [COORD_W-1:0] dest_col;
  } result_t;

  // atan(2^-i), 2^32 units per turn
  localparam logic [31:0] ATAN_TURNS [0:CORDIC_MAX-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

`default_nettype wire

FILE: rtl/core/fft_bin_polar_with_quadrant_shift.sv
// Top level of the FFT bin polar converter with quadrant swap.
// Depends on fbp_pkg, fbp_mag_pipe and fbp_cordic_pipe.
//
// Usage:
//  - in_ channel: one FFT bin per word (real, imaginary, row, column).
//  - out_ channel: normalised magnitude (8 fraction bits, saturating), phase
//    level 0..255 (8 fraction bits) and the fftshifted row and column.
//  - cfg_ channel: side_log2 of the square grid, always ready; write it only
//    while no word is in flight. Values above MAX_SIDE_LOG2 act as the max.
//  - Throughput: one word per cycle while in_ready is high. A word that is
//    captured passes squaring, pre-shift, the 32-stage square root, the
//    post-shift register and the output register before it shows on out_.
//    The phase path (pre-rotate, 32 rotator slots, clamp, scale) is matched.
//  - Stall: while out_valid waits, one more word is parked in a skid
//    register; only when that is full does in_ready drop and the pipe freeze.
//    in_ready comes straight from a flop.
//  - Reset (rst_n low, synchronous): all valids clear, side_log2 returns to 9.
`default_nettype none

module fft_bin_polar_with_quadrant_shift #(
  parameter int MAX_SIDE_LOG2 = fbp_pkg::MAX_SIDE_LOG2_DEF,
  parameter int CORDIC_STAGES = fbp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            in_real_part,
  input  logic signed [31:0]            in_imag_part,
  input  logic [9:0]                    in_bin_row,
  input  logic [9:0]                    in_bin_col,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [23:0]                   out_magnitude,
  output logic [15:0]                   out_phase_level,
  output logic [9:0]                    out_dest_row,
  output logic [9:0]                    out_dest_col,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [3:0]                    cfg_side_log2
);

  localparam int DEPTH   = fbp_pkg::PIPE_DEPTH;
  localparam int COORD_W = fbp_pkg::COORD_W;
  localparam int CRD_W   = ((MAX_SIDE_LOG2 > COORD_W) ? MAX_SIDE_LOG2 : COORD_W) + 1;
  localparam logic [fbp_pkg::CFG_W-1:0] K_MAX = fbp_pkg::CFG_W'(MAX_SIDE_LOG2);

  logic [fbp_pkg::CFG_W-1:0] side_log2_r;
  logic [fbp_pkg::CFG_W-1:0] k_eff;
  logic [CRD_W-1:0]          side, half, mask;
  logic [CRD_W-1:0]          row_sum, col_sum;

  fbp_pkg::pipe_ctl_t ctl;
  logic               adv;

  fbp_pkg::sample_t   re0_r, im0_r;
  logic [DEPTH:0]     v_r;
  logic [COORD_W-1:0] row_r [0:DEPTH];
  logic [COORD_W-1:0] col_r [0:DEPTH];

  logic [fbp_pkg::MAG_W-1:0]   mag;
  logic [fbp_pkg::PHASE_W-1:0] phase;

  fbp_pkg::result_t last, out_r, skid_r;
  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  logic             out_load, out_from_skid, skid_load;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_log2_r <= fbp_pkg::SIDE_LOG2_RST;
    end else if (cfg_valid) begin
      side_log2_r <= cfg_side_log2;
    end
  end

  assign cfg_ready = 1'b1;
  assign k_eff     = (side_log2_r > K_MAX) ? K_MAX : side_log2_r;

  assign adv      = !skid_valid_r;
  assign in_ready = adv;
  assign ctl.adv       = adv;
  assign ctl.side_log2 = k_eff;

  // quadrant swap
  assign side    = CRD_W'(1) << k_eff;
  assign half    = side >> 1;
  assign mask    = side - CRD_W'(1);
  assign row_sum = (CRD_W'(in_bin_row) + half) & mask;
  assign col_sum = (CRD_W'(in_bin_col) + half) & mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[DEPTH-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      re0_r    <= in_real_part;
      im0_r    <= in_imag_part;
      row_r[0] <= row_sum[COORD_W-1:0];
      col_r[0] <= col_sum[COORD_W-1:0];
      for (int s = 1; s <= DEPTH; s++) begin
        row_r[s] <= row_r[s-1];
        col_r[s] <= col_r[s-1];
      end
    end
  end

  fbp_mag_pipe u_mag (
    .clk (clk),
    .ctl (ctl),
    .re  (re0_r),
    .im  (im0_r),
    .mag (mag)
  );

  fbp_cordic_pipe #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk   (clk),
    .ctl   (ctl),
    .re    (re0_r),
    .im    (im0_r),
    .phase (phase)
  );

  assign last.magnitude   = mag;
  assign last.phase_level = phase;
  assign last.dest_row    = row_r[DEPTH];
  assign last.dest_col    = col_r[DEPTH];

  // output register plus one-word skid
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_load       = 1'b0;
    out_from_skid  = 1'b0;
    skid_load      = 1'b0;
    if (adv) begin
      if (!out_valid_r || out_ready) begin
        out_valid_nxt = v_r[DEPTH];
        out_load      = 1'b1;
      end else if (v_r[DEPTH]) begin
        skid_valid_nxt = 1'b1;
        skid_load      = 1'b1;
      end
    end else if (out_ready) begin
      out_from_skid  = 1'b1;
      skid_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= last;
    end else if (out_from_skid) begin
      out_r <= skid_r;
    end
    if (skid_load) begin
      skid_r <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_magnitude   = out_r.magnitude;
  assign out_phase_level = out_r.phase_level;
  assign out_dest_row    = out_r.dest_row;
  assign out_dest_col    = out_r.dest_col;

endmodule

`default_nettype wire

FILE: rtl/core/fbp_mag_pipe.sv
// Magnitude path: squares, normalising pre-shift, pipelined bit-per-stage
// square root and post-shift with saturation.
// Depends on fbp_pkg.
`default_nettype none

module fbp_mag_pipe (
  input  logic                       clk,
  input  fbp_pkg::pipe_ctl_t         ctl,
  input  fbp_pkg::sample_t           re,
  input  fbp_pkg::sample_t           im,
  output logic [fbp_pkg::MAG_W-1:0]  mag
);

  localparam int SQ_W  = fbp_pkg::SQ_W;
  localparam int STEPS = fbp_pkg::SQRT_STEPS;

  logic signed [SQ_W-1:0] re_sq, im_sq;
  logic [SQ_W-1:0]        re_sq_r, im_sq_r;
  logic [SQ_W-1:0]        sq;
  logic                   small_k;
  logic [4:0]             lsh;
  logic [5:0]             thr;
  logic [SQ_W-1:0]        rad;
  logic                   sat;

  logic [SQ_W-1:0] rem_r  [0:STEPS];
  logic [SQ_W-1:0] root_r [0:STEPS];
  logic            sat_r  [0:STEPS];

  logic [31:0]                root_fin;
  logic [4:0]                 rsh;
  logic [31:0]                root_sh;
  logic [fbp_pkg::MAG_W-1:0]  mag_nxt;
  logic [fbp_pkg::MAG_W-1:0]  mag_r;

  // operands sign-extend to the product width
  assign re_sq = re * re;
  assign im_sq = im * im;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      re_sq_r <= $unsigned(re_sq);
      im_sq_r <= $unsigned(im_sq);
    end
  end

  // small sides scale up before the root, large ones scale down after it
  assign sq      = re_sq_r + im_sq_r;
  assign small_k = (ctl.side_log2 < 4'd4);
  assign lsh     = 5'd16 - {1'b0, ctl.side_log2[1:0], 2'b00};
  assign thr     = 6'd32 + {2'b00, ctl.side_log2[1:0], 2'b00};
  assign sat     = small_k && ((sq >> thr) != '0);
  assign rad     = small_k ? (sq << lsh) : sq;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      rem_r[0]  <= rad;
      root_r[0] <= '0;
      sat_r[0]  <= sat;
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (STEPS - 1 - j));
    logic [SQ_W:0] trial;
    logic          take;

    assign trial = {1'b0, root_r[j]} + {1'b0, BIT};
    assign take  = ({1'b0, rem_r[j]} >= trial);

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        rem_r[j+1]  <= take ? (rem_r[j] - trial[SQ_W-1:0]) : rem_r[j];
        root_r[j+1] <= take ? ((root_r[j] >> 1) + BIT) : (root_r[j] >> 1);
        sat_r[j+1]  <= sat_r[j];
      end
    end
  end

  assign root_fin = root_r[STEPS][31:0];
  assign rsh      = 5'({ctl.side_log2, 1'b0}) - 5'd8;
  assign root_sh  = root_fin >> rsh;

  always_comb begin
    if (sat_r[STEPS]) begin
      mag_nxt = fbp_pkg::MAG_MAX;
    end else if (small_k) begin
      mag_nxt = root_fin[fbp_pkg::MAG_W-1:0];
    end else if (root_sh > 32'(fbp_pkg::MAG_MAX)) begin
      mag_nxt = fbp_pkg::MAG_MAX;
    end else begin
      mag_nxt = root_sh[fbp_pkg::MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      mag_r <= mag_nxt;
    end
  end

  assign mag = mag_r;

endmodule

`default_nettype wire

FILE: rtl/core/fbp_cordic_pipe.sv
// Phase path: half-plane pre-rotation, unrolled vectoring CORDIC, clamp and
// scale of the angle to 0..255 with 8 fraction bits.
// Depends on fbp_pkg.
`default_nettype none

module fbp_cordic_pipe #(
  parameter int CORDIC_STAGES = fbp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                        clk,
  input  fbp_pkg::pipe_ctl_t          ctl,
  input  fbp_pkg::sample_t            re,
  input  fbp_pkg::sample_t            im,
  output logic [fbp_pkg::PHASE_W-1:0] phase
);

  localparam int NSLOT = fbp_pkg::CORDIC_MAX;
  localparam int PW    = 49;
  localparam fbp_pkg::cval_t HALF_TURN = fbp_pkg::cval_t'(64'sh8000_0000);
  localparam fbp_pkg::cval_t FULL_TURN = fbp_pkg::cval_t'(64'sh1_0000_0000);
  localparam logic [PW-1:0]  ROUND     = PW'(64'h8000_0000);

  fbp_pkg::cval_t re_x, im_x, x0, y0, z0;
  fbp_pkg::cval_t x_r [0:NSLOT];
  fbp_pkg::cval_t y_r [0:NSLOT];
  fbp_pkg::cval_t z_r [0:NSLOT];

  fbp_pkg::cval_t               u;
  logic [32:0]                  u_nxt, u_r;
  logic [PW-1:0]                prod;
  logic [fbp_pkg::PHASE_W-1:0]  phase_r;

  assign re_x = fbp_pkg::cval_t'(re);
  assign im_x = fbp_pkg::cval_t'(im);

  // left half-plane: negate and start half a turn round
  always_comb begin
    if (re[fbp_pkg::DATA_W-1]) begin
      x0 = -re_x;
      y0 = -im_x;
      z0 = im[fbp_pkg::DATA_W-1] ? -HALF_TURN : HALF_TURN;
    end else begin
      x0 = re_x;
      y0 = im_x;
      z0 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      x_r[0] <= x0;
      y_r[0] <= y0;
      z_r[0] <= z0;
    end
  end

  for (genvar i = 0; i < NSLOT; i++) begin : g_rot
    if (i < CORDIC_STAGES) begin : g_live
      localparam fbp_pkg::cval_t ANG =
        $signed(fbp_pkg::CORDIC_W'(fbp_pkg::ATAN_TURNS[i]));
      fbp_pkg::cval_t xs, ys;

      assign xs = x_r[i] >>> i;
      assign ys = y_r[i] >>> i;

      // y at zero ends the rotation: the word just rides along
      always_ff @(posedge clk) begin
        if (ctl.adv) begin
          if (y_r[i] == '0) begin
            x_r[i+1] <= x_r[i];
            y_r[i+1] <= y_r[i];
            z_r[i+1] <= z_r[i];
          end else if (!y_r[i][fbp_pkg::CORDIC_W-1]) begin
            x_r[i+1] <= x_r[i] + ys;
            y_r[i+1] <= y_r[i] - xs;
            z_r[i+1] <= z_r[i] + ANG;
          end else begin
            x_r[i+1] <= x_r[i] - ys;
            y_r[i+1] <= y_r[i] + xs;
            z_r[i+1] <= z_r[i] - ANG;
          end
        end
      end
    end else begin : g_idle
      always_ff @(posedge clk) begin
        if (ctl.adv) begin
          x_r[i+1] <= x_r[i];
          y_r[i+1] <= y_r[i];
          z_r[i+1] <= z_r[i];
        end
      end
    end
  end

  assign u = z_r[NSLOT] + HALF_TURN;

  always_comb begin
    if (u < 0) begin
      u_nxt = '0;
    end else if (u > FULL_TURN) begin
      u_nxt = FULL_TURN[32:0];
    end else begin
      u_nxt = u[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      u_r <= u_nxt;
    end
  end

  assign prod = PW'(u_r) * PW'(fbp_pkg::PHASE_SCALE) + ROUND;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      phase_r <= prod[47:32];
    end
  end

  assign phase = phase_r;

endmodule

`default_nettype wire

FILE: rtl/core/fbp_port_chk.sv
// Port-level checks for fft_bin_polar_with_quadrant_shift, bound to the top.
// Depends on fbp_pkg and the top level's port list.
`default_nettype none

module fbp_port_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_phase_level
);

  // a held result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out word dropped while stalled");

  // reset empties the output side
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // input back-pressure only ever comes from a waiting result word
  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with no word on out_");

  // phase never exceeds a full 255 level
  a_phase_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_phase_level <= fbp_pkg::PHASE_SCALE))
    else $error("phase level out of range");

endmodule

bind fft_bin_polar_with_quadrant_shift fbp_port_chk u_port_chk (.*);

`default_nettype wire
